FILE: rtl/core/bmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pkg: shared constants for the binomial modulo prime block
// Field widths, the prime and the Fermat exponent used for the inverse.
// ----------------------------------------------------------------------------
package bmp_pkg;

  localparam int TOP_W   = 30;
  localparam int PICK_W  = 19;
  localparam int VALUE_W = 30;

  localparam int MAX_K_DEF = 262144;

  localparam logic [TOP_W-1:0] PRIME   = 30'd998244353;
  localparam logic [TOP_W-1:0] INV_EXP = 30'd998244351;
  localparam logic [31:0]      PRIME_X1 = 32'd998244353;
  localparam logic [31:0]      PRIME_X2 = 32'd1996488706;

  localparam int BIT_W = $clog2(TOP_W);

endpackage

FILE: rtl/core/bmp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_in_if: request channel
// Valid/ready channel carrying the top value and the choose count.
// ----------------------------------------------------------------------------
interface bmp_in_if;
  logic                       valid;
  logic                       ready;
  logic [bmp_pkg::TOP_W-1:0]  top;
  logic [bmp_pkg::PICK_W-1:0] pick;

  modport source (output valid, output top, output pick, input ready);
  modport sink   (input valid, input top, input pick, output ready);
endinterface

FILE: rtl/core/bmp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_out_if: result channel
// Valid/ready channel carrying the reduced binomial coefficient.
// ----------------------------------------------------------------------------
interface bmp_out_if;
  logic                        valid;
  logic                        ready;
  logic [bmp_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: rtl/core/bmp_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_mulmod: bit-serial modular multiplier
// Computes a*b mod PRIME, one multiplier bit per cycle, MSB first, with a
// shift, add and conditional subtract each cycle.
// ----------------------------------------------------------------------------
module bmp_mulmod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bmp_pkg::TOP_W-1:0] a,
  input  logic [bmp_pkg::TOP_W-1:0] b,
  output logic                      done,
  output logic [bmp_pkg::TOP_W-1:0] prod
);

  logic [bmp_pkg::TOP_W-1:0] mcand;
  logic [bmp_pkg::TOP_W-1:0] mplier;
  logic [bmp_pkg::TOP_W-1:0] acc;
  logic [bmp_pkg::BIT_W-1:0] cnt;
  logic                      busy;
  logic [31:0]               sum;
  logic [31:0]               red;

  always_comb begin
    sum = {1'b0, acc, 1'b0} + (mplier[bmp_pkg::TOP_W-1] ? {2'b00, mcand} : 32'd0);
    priority if (sum >= bmp_pkg::PRIME_X2) begin
      red = sum - bmp_pkg::PRIME_X2;
    end else if (sum >= bmp_pkg::PRIME_X1) begin
      red = sum - bmp_pkg::PRIME_X1;
    end else begin
      red = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      mplier <= b;
      acc    <= '0;
      cnt    <= bmp_pkg::BIT_W'(bmp_pkg::TOP_W - 1);
    end else if (busy) begin
      acc    <= red[bmp_pkg::TOP_W-1:0];
      mplier <= {mplier[bmp_pkg::TOP_W-2:0], 1'b0};
      cnt    <= cnt - 1'b1;
    end
  end

  assign prod = acc;

endmodule

FILE: rtl/core/binomial_mod_prime.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_mod_prime: binomial coefficient modulo 998244353
// Returns C(top, pick) mod 998244353 via a falling product and a Fermat
// inverse of pick!, all on one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   req carries top and pick; a transfer happens when valid and ready are
//   both high. ready is high only while the block is idle, so one item is
//   in work at a time. rsp carries value and holds it with valid high
//   until the receiver takes it; a stalled receiver simply keeps the block
//   busy, and no new request is taken until that transfer.
//   pick above MAX_K is saturated to MAX_K; a saturated pick above top gives zero.
// Sequence:
//   Every modular multiply runs on the shared multiplier. An item takes two
//   multiplies and one step state per factor of the saturated pick k, then
//   58 multiplies for the exponentiation and one final multiply; a
//   saturated pick above top skips the multiplier.
// Reset:
//   rst is synchronous and returns the sequencer to idle; any item in work
//   is dropped. No state is kept between items.
// ----------------------------------------------------------------------------
module binomial_mod_prime #(
  parameter int MAX_K = bmp_pkg::MAX_K_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bmp_in_if.sink    req,
  bmp_out_if.source rsp
);

  localparam int TW   = bmp_pkg::TOP_W;
  localparam int CW   = $clog2(MAX_K + 1);
  localparam int CMPW = (CW > bmp_pkg::PICK_W) ? CW : bmp_pkg::PICK_W;
  localparam logic [CMPW-1:0] MAXK_C = CMPW'(MAX_K);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_STEP = 8'b00000010,
    S_NUM  = 8'b00000100,
    S_DEN  = 8'b00001000,
    S_EXPB = 8'b00010000,
    S_SQ   = 8'b00100000,
    S_MUL  = 8'b01000000,
    S_FIN  = 8'b10000000
  } state_t;

  state_t                      state, state_next;
  logic                        out_valid, out_valid_next;
  logic [bmp_pkg::VALUE_W-1:0] value, value_next;
  logic [TW-1:0]               num, num_next;
  logic [TW-1:0]               den, den_next;
  logic [TW-1:0]               fac, fac_next;
  logic [TW-1:0]               acc, acc_next;
  logic [CW-1:0]               cnt, cnt_next;
  logic [CW-1:0]               kmax, kmax_next;
  logic [bmp_pkg::BIT_W-1:0]   bidx, bidx_next;

  logic          mm_start;
  logic [TW-1:0] mm_a;
  logic [TW-1:0] mm_b;
  logic          mm_done;
  logic [TW-1:0] mm_prod;

  logic [CMPW-1:0] pick_ext;
  logic [CMPW-1:0] pick_sat;

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.value = value;

  always_comb begin
    pick_ext = CMPW'(req.pick);
    pick_sat = (pick_ext > MAXK_C) ? MAXK_C : pick_ext;
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    value_next     = value;
    num_next       = num;
    den_next       = den;
    fac_next       = fac;
    acc_next       = acc;
    cnt_next       = cnt;
    kmax_next      = kmax;
    bidx_next      = bidx;
    mm_start       = 1'b0;
    mm_a           = num;
    mm_b           = fac;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          if (TW'(pick_sat) > req.top) begin
            value_next     = '0;
            out_valid_next = 1'b1;
          end else begin
            fac_next   = (req.top >= bmp_pkg::PRIME) ? req.top - bmp_pkg::PRIME : req.top;
            num_next   = TW'(1);
            den_next   = TW'(1);
            cnt_next   = '0;
            kmax_next  = CW'(pick_sat);
            state_next = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (cnt == kmax) begin
          acc_next   = TW'(1);
          bidx_next  = bmp_pkg::BIT_W'(TW - 1);
          state_next = S_EXPB;
        end else begin
          mm_start   = 1'b1;
          mm_a       = num;
          mm_b       = fac;
          state_next = S_NUM;
        end
      end
      S_NUM: begin
        if (mm_done) begin
          num_next   = mm_prod;
          mm_start   = 1'b1;
          mm_a       = den;
          mm_b       = TW'(cnt) + TW'(1);
          state_next = S_DEN;
        end
      end
      S_DEN: begin
        if (mm_done) begin
          den_next   = mm_prod;
          cnt_next   = cnt + 1'b1;
          fac_next   = (fac == '0) ? bmp_pkg::PRIME - TW'(1) : fac - TW'(1);
          state_next = S_STEP;
        end
      end
      S_EXPB: begin
        mm_start   = 1'b1;
        mm_a       = acc;
        mm_b       = acc;
        state_next = S_SQ;
      end
      S_SQ: begin
        if (mm_done) begin
          acc_next = mm_prod;
          mm_start = 1'b1;
          priority if (bmp_pkg::INV_EXP[bidx]) begin
            mm_a       = mm_prod;
            mm_b       = den;
            state_next = S_MUL;
          end else if (bidx == '0) begin
            mm_a       = num;
            mm_b       = mm_prod;
            state_next = S_FIN;
          end else begin
            bidx_next  = bidx - 1'b1;
            mm_a       = mm_prod;
            mm_b       = mm_prod;
            state_next = S_SQ;
          end
        end
      end
      S_MUL: begin
        if (mm_done) begin
          acc_next = mm_prod;
          mm_start = 1'b1;
          if (bidx == '0) begin
            mm_a       = num;
            mm_b       = mm_prod;
            state_next = S_FIN;
          end else begin
            bidx_next  = bidx - 1'b1;
            mm_a       = mm_prod;
            mm_b       = mm_prod;
            state_next = S_SQ;
          end
        end
      end
      S_FIN: begin
        if (mm_done) begin
          value_next     = mm_prod;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    num   <= num_next;
    den   <= den_next;
    fac   <= fac_next;
    acc   <= acc_next;
    cnt   <= cnt_next;
    kmax  <= kmax_next;
    bidx  <= bidx_next;
  end

  bmp_mulmod u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .done  (mm_done),
    .prod  (mm_prod)
  );

endmodule

FILE: bench/tb_binomial_mod_prime.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binomial_mod_prime: self-checking bench for the binomial modulo prime
// Sends (top, pick) requests over the valid/ready request channel, predicts
// C(top, pick) mod 998244353 for every accepted request and compares each
// returned value in order. Directed corner cases come first, then random
// requests with small choose counts. Random gaps on the sender and random
// stalls on the receiver are applied, with two drain pauses on the sender.
// ----------------------------------------------------------------------------
module tb_binomial_mod_prime;

  localparam longint unsigned MODP  = bmp_pkg::PRIME;
  localparam longint unsigned KSAT  = bmp_pkg::MAX_K_DEF;
  localparam logic [bmp_pkg::TOP_W-1:0]  TOP_MAX  = '1;
  localparam logic [bmp_pkg::PICK_W-1:0] PICK_MAX = '1;

  typedef struct {
    logic [bmp_pkg::TOP_W-1:0]  top;
    logic [bmp_pkg::PICK_W-1:0] pick;
    bit                         drain;
  } bmp_req_t;

  logic clk;
  logic rst;

  bmp_in_if  req_if ();
  bmp_out_if rsp_if ();

  binomial_mod_prime u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  bmp_req_t                    pending_q [$];
  logic [bmp_pkg::VALUE_W-1:0] coeff_q [$];
  bit                          req_taken;
  int                          sent_cnt;
  int                          got_cnt;
  int                          err_cnt;

  function automatic longint unsigned mul_p(longint unsigned a, longint unsigned b);
    return ((a % MODP) * (b % MODP)) % MODP;
  endfunction

  function automatic longint unsigned pow_p(longint unsigned b, longint unsigned e);
    longint unsigned acc;
    acc = 1;
    b = b % MODP;
    while (e != 0) begin
      if (e[0]) acc = mul_p(acc, b);
      b = mul_p(b, b);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [bmp_pkg::VALUE_W-1:0] binom_p(
    logic [bmp_pkg::TOP_W-1:0] top, logic [bmp_pkg::PICK_W-1:0] pick);
    longint unsigned n, k, num, den, i;
    n = top;
    k = pick;
    if (k > KSAT) k = KSAT;
    if (k > n) return '0;
    num = 1;
    den = 1;
    for (i = 0; i < k; i++) num = mul_p(num, n - i);
    for (i = 2; i <= k; i++) den = mul_p(den, i);
    return bmp_pkg::VALUE_W'(mul_p(num, pow_p(den, MODP - 2)));
  endfunction

  task automatic add_req(logic [bmp_pkg::TOP_W-1:0] top, logic [bmp_pkg::PICK_W-1:0] pick,
                         bit drain);
    bmp_req_t it;
    it.top   = top;
    it.pick  = pick;
    it.drain = drain;
    pending_q.insert(pending_q.size(), it);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  initial begin
    #320_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // stimulus
  initial begin
    logic [bmp_pkg::TOP_W-1:0]  t;
    logic [bmp_pkg::PICK_W-1:0] p;
    longint unsigned            plim;
    int                         r;

    add_req(30'd0, 19'd0, 1'b0);
    add_req(30'd0, 19'd1, 1'b0);
    add_req(30'd1, 19'd1, 1'b0);
    add_req(30'd5, 19'd2, 1'b0);
    add_req(30'd10, 19'd10, 1'b0);
    add_req(30'd10, 19'd11, 1'b0);
    add_req(30'd200, 19'd199, 1'b0);
    add_req(30'd200, 19'd200, 1'b0);
    add_req(TOP_MAX, 19'd3, 1'b0);
    add_req(TOP_MAX, 19'd30, 1'b0);
    add_req(30'd100, PICK_MAX, 1'b0);
    add_req(30'd262143, 19'd262144, 1'b0);
    add_req(30'd262143, 19'd262145, 1'b0);
    add_req(bmp_pkg::PRIME - 30'd1, 19'd5, 1'b0);
    add_req(bmp_pkg::PRIME, 19'd0, 1'b0);
    add_req(bmp_pkg::PRIME, 19'd1, 1'b0);
    add_req(bmp_pkg::PRIME + 30'd7, 19'd12, 1'b0);
    add_req(bmp_pkg::PRIME + 30'd20, 19'd3, 1'b0);
    add_req(30'd1000, 19'd2000, 1'b0);
    add_req(30'd123456789, 19'd2000, 1'b1);
    add_req(30'h2AAAAAAA, 19'd17, 1'b0);
    add_req(30'h15555555, 19'd64, 1'b0);

    for (int n = 0; n < 78; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35)      t = bmp_pkg::TOP_W'($urandom());
      else if (r < 65) t = bmp_pkg::TOP_W'($urandom_range(0, 64));
      else if (r < 85) t = bmp_pkg::TOP_W'($urandom_range(bmp_pkg::PRIME - 64,
                                                          bmp_pkg::PRIME + 64));
      else             t = bmp_pkg::TOP_W'($urandom_range(TOP_MAX - 64, TOP_MAX));

      r = $urandom_range(0, 99);
      if (r < 80)      p = bmp_pkg::PICK_W'($urandom_range(0, 40));
      else if (r < 95) p = bmp_pkg::PICK_W'($urandom_range(41, 300));
      else             p = bmp_pkg::PICK_W'($urandom_range(301, 1000));

      // wide count above the top: zero result, no long computation
      if ($urandom_range(0, 19) == 0) begin
        p    = bmp_pkg::PICK_W'($urandom());
        plim = (p > KSAT) ? KSAT : longint'(p);
        t    = (p == 0) ? '0 : bmp_pkg::TOP_W'($urandom_range(0, 32'(plim - 1)));
      end
      add_req(t, p, n == 70);
    end
  end

  // request driver
  always @(negedge clk) begin
    bmp_req_t it;
    if (rst) begin
      req_if.valid <= 1'b0;
      req_if.top   <= '0;
      req_if.pick  <= '0;
    end else if (!req_if.valid || req_taken) begin
      if (pending_q.size() != 0 && !(pending_q[0].drain && coeff_q.size() != 0) &&
          ((sent_cnt >= 45 && sent_cnt < 65) || $urandom_range(0, 99) >= 10)) begin
        it = pending_q.pop_front();
        req_if.valid <= 1'b1;
        req_if.top   <= it.top;
        req_if.pick  <= it.pick;
        sent_cnt++;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= (got_cnt >= 45 && got_cnt < 65) || ($urandom_range(0, 99) >= 10);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    logic [bmp_pkg::VALUE_W-1:0] want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
        got_cnt++;
        if (coeff_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected transfer: value=%0d", rsp_if.value);
        end else begin
          want = coeff_q.pop_front();
          if (rsp_if.value !== want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch on result %0d: expected value=%0d actual value=%0d",
                       got_cnt, want, rsp_if.value);
          end
        end
      end
      if (req_if.valid && req_if.ready)
        coeff_q.insert(coeff_q.size(), binom_p(req_if.top, req_if.pick));
    end
  end

  initial begin
    @(negedge clk);
    while (rst) @(posedge clk);
    while (pending_q.size() != 0 || req_if.valid || coeff_q.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bmp_pkg.sv
rtl/core/bmp_in_if.sv
rtl/core/bmp_out_if.sv
rtl/core/bmp_mulmod.sv
rtl/core/binomial_mod_prime.sv
bench/tb_binomial_mod_prime.sv
